@@ sv/dspt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspt_pkg
// Types, constants and helpers shared by the degradation step transition unit.
// ----------------------------------------------------------------------------
package dspt_pkg;

  localparam int unsigned MaxSteps = 32;
  localparam int unsigned MaxDyes  = 7;
  localparam int unsigned StepW    = 5;
  localparam int unsigned CountW   = 3;
  localparam int unsigned ProbW    = 32;
  localparam int unsigned AddrW    = 1 + StepW + 2 * CountW;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ProbW-1:0]  QOne       = 32'h8000_0000;
  localparam logic [CountW-1:0] CountMax   = CountW'(MaxDyes);
  localparam logic [StepW-1:0]  LastStepRst = StepW'(MaxSteps - 1);

  typedef enum logic [1:0] {
    ACT_DYE  = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_COMP = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  localparam logic [CfgIdxW-1:0] CFG_P_FAILURE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LAST_STEP = 2'd2;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [StepW-1:0]  step_index;
    logic [1:0]        dye_channel;
    logic [CountW-1:0] count_first;
    logic [CountW-1:0] count_second;
    logic              broken_plane;
    logic [ProbW-1:0]  prob_value;
  } in_t;

  typedef struct packed {
    logic [ProbW-1:0] read_value;
    logic             done_flag;
    logic             saturated;
  } out_t;

  function automatic logic [ProbW-1:0] clamp_one(logic [ProbW-1:0] v);
    return (v > QOne) ? QOne : v;
  endfunction

  function automatic logic [AddrW-1:0] tensor_addr(logic plane, logic [StepW-1:0] t,
                                                   logic [CountW-1:0] a,
                                                   logic [CountW-1:0] b);
    return {plane, t, a, b};
  endfunction

  // n/d truncated to Q1.31, one when n >= d or d is zero
  function automatic logic [ProbW-1:0] q_ratio(logic [CountW-1:0] n, logic [CountW-1:0] d);
    logic [ProbW-1:0] r;
    r = QOne;
    if (d != '0 && n < d) begin
      case ({d, n})
        6'o21: r = 32'h4000_0000;
        6'o31: r = 32'h2AAA_AAAA;
        6'o32: r = 32'h5555_5555;
        6'o41: r = 32'h2000_0000;
        6'o42: r = 32'h4000_0000;
        6'o43: r = 32'h6000_0000;
        6'o51: r = 32'h1999_9999;
        6'o52: r = 32'h3333_3333;
        6'o53: r = 32'h4CCC_CCCC;
        6'o54: r = 32'h6666_6666;
        6'o61: r = 32'h1555_5555;
        6'o62: r = 32'h2AAA_AAAA;
        6'o63: r = 32'h4000_0000;
        6'o64: r = 32'h5555_5555;
        6'o65: r = 32'h6AAA_AAAA;
        6'o71: r = 32'h1249_2492;
        6'o72: r = 32'h2492_4924;
        6'o73: r = 32'h36DB_6DB6;
        6'o74: r = 32'h4924_9249;
        6'o75: r = 32'h5B6D_B6DB;
        6'o76: r = 32'h6DB6_DB6D;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/dspt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dspt_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/dspt_qmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspt_qmul
// Shared Q1.31 multiplier with truncation and a registered product.
// ----------------------------------------------------------------------------
module dspt_qmul
  import dspt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [ProbW-1:0] x_i,
  input  wire logic [ProbW-1:0] y_i,
  output logic      [ProbW-1:0] prod_o
);

  logic [2*ProbW-1:0] full;

  assign full = {{ProbW{1'b0}}, x_i} * {{ProbW{1'b0}}, y_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= full[2*ProbW-2:ProbW-1];
    end
  end

endmodule
`default_nettype wire

@@ sv/degradation_step_prob_transition_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// degradation_step_prob_transition_unit
// One forward or backward degradation step over a Q1.31 probability tensor.
// ----------------------------------------------------------------------------
// Dye and load items: result in the cycle after acceptance; reads via ST_READ.
// Compute: a sweep of the output RAM (clear, copy broken plane to last_q), then
// RD_F, LD_F, PF, ACC plus C1/C2, CF, ACC per transition for each normal-plane
// state, 64 per step in use; all products use the single shared multiplier and
// the output RAM port. One item at a time: a beat is taken once idle with the
// result register free. After reset both RAMs are zeroed before items are taken.
// ----------------------------------------------------------------------------
module degradation_step_prob_transition_unit
  import dspt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ProbW-1:0]   cfg_data_i
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SWEEP, ST_RD_F, ST_LD_F,
    ST_PF, ST_C1, ST_C2, ST_CF, ST_ACC, ST_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [AddrW:0]      cnt_q, cnt_d;
  logic                sw_vld_q, sw_vld_d;
  logic [AddrW-1:0]    sw_addr_q, sw_addr_d;
  logic [StepW-1:0]    t_q, t_d;
  logic [CountW-1:0]   a_q, a_d, b_q, b_d;
  logic [1:0]          part_q, part_d;
  logic [ProbW-1:0]    f_q, f_d;
  logic [AddrW-1:0]    acc_addr_q, acc_addr_d;
  logic                clip_q, clip_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic [ProbW-1:0]    pf_q;
  logic                dir_q;
  logic [StepW-1:0]    last_q;
  logic [7:0]          dye_q [MaxSteps];

  logic                in_we, out_we, mul_en, dye_we;
  logic [AddrW-1:0]    in_waddr, in_raddr, out_waddr, out_raddr;
  logic [ProbW-1:0]    in_wdata, out_wdata, in_rdata, out_rdata;
  logic [ProbW-1:0]    mul_x, mul_y, prod;

  logic                out_free, in_acc;
  logic [ProbW-1:0]    pf_c, succ;
  logic [StepW-1:0]    dye_idx, dst_t;
  logic [7:0]          dye_e;
  logic [1:0]          ch;
  logic                nodye, do_trans, stay_ok, nbr_ok, last_ent;
  logic [CountW-1:0]   total, x, n2, nbr_a, nbr_b;
  logic [ProbW-1:0]    r1, r2, coef1;
  logic [AddrW-1:0]    here, stay_addr, nbr_addr, in_addr;
  logic [ProbW:0]      sum;
  logic                sum_clip;

  dspt_ram #(.AW(AddrW), .DW(ProbW)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_waddr),
    .wdata_i (in_wdata),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  dspt_ram #(.AW(AddrW), .DW(ProbW)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_waddr),
    .wdata_i (out_wdata),
    .raddr_i (out_raddr),
    .rdata_o (out_rdata)
  );

  dspt_qmul u_qmul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_o (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;

  // transition decode for the current state (t, a, b)
  assign pf_c     = clamp_one(pf_q);
  assign succ     = QOne - pf_c;
  assign dye_idx  = dir_q ? (t_q - StepW'(1)) : t_q;
  assign dye_e    = dye_q[dye_idx];
  assign ch       = dye_e[1:0];
  assign nodye    = (ch != CH_ONE) && (ch != CH_TWO);
  assign total    = (ch == CH_ONE) ? dye_e[4:2] : dye_e[7:5];
  assign x        = (ch == CH_ONE) ? a_q : b_q;
  assign n2       = dir_q ? (x + CountW'(1)) : x;
  assign r1       = q_ratio(x, total);
  assign r2       = q_ratio(n2, total);
  assign coef1    = nodye ? QOne : (QOne - r1);
  assign do_trans = dir_q ? (t_q != '0) : (t_q < last_q);
  assign stay_ok  = nodye || (x < total);
  assign nbr_ok   = !nodye && (dir_q ? (x != CountMax) : (x != '0));
  assign dst_t    = dir_q ? (t_q - StepW'(1)) : (t_q + StepW'(1));
  assign nbr_a    = (ch == CH_ONE) ? (dir_q ? a_q + CountW'(1) : a_q - CountW'(1)) : a_q;
  assign nbr_b    = (ch == CH_TWO) ? (dir_q ? b_q + CountW'(1) : b_q - CountW'(1)) : b_q;
  assign here      = tensor_addr(1'b0, t_q, a_q, b_q);
  assign stay_addr = tensor_addr(1'b0, dst_t, a_q, b_q);
  assign nbr_addr  = tensor_addr(1'b0, dst_t, nbr_a, nbr_b);
  assign last_ent  = (t_q == last_q) && (a_q == CountMax) && (b_q == CountMax);
  assign in_addr   = tensor_addr(in_data_i.broken_plane, in_data_i.step_index,
                                 in_data_i.count_first, in_data_i.count_second);
  assign sum       = {1'b0, out_rdata} + {1'b0, prod};
  assign sum_clip  = sum > {1'b0, QOne};
  assign dye_we    = in_acc && (in_data_i.action == ACT_DYE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sw_vld_d    = 1'b0;
    sw_addr_d   = sw_addr_q;
    t_d         = t_q;
    a_d         = a_q;
    b_d         = b_q;
    part_d      = part_q;
    f_d         = f_q;
    acc_addr_d  = acc_addr_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    in_we       = 1'b0;
    in_waddr    = in_addr;
    in_wdata    = clamp_one(in_data_i.prob_value);
    in_raddr    = here;
    out_we      = 1'b0;
    out_waddr   = acc_addr_q;
    out_wdata   = sum_clip ? QOne : sum[ProbW-1:0];
    out_raddr   = in_addr;
    mul_en      = 1'b0;
    mul_x       = succ;
    mul_y       = coef1;

    unique case (state_q)
      ST_CLEAR: begin
        in_we     = 1'b1;
        in_waddr  = cnt_q[AddrW-1:0];
        in_wdata  = '0;
        out_we    = 1'b1;
        out_waddr = cnt_q[AddrW-1:0];
        out_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (&cnt_q[AddrW-1:0]) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(in_data_i.action))
            ACT_DYE: begin
              out_valid_d = 1'b1;
              out_d       = '{read_value: '0, done_flag: 1'b1, saturated: clip_q};
            end
            ACT_LOAD: begin
              in_we       = 1'b1;
              out_valid_d = 1'b1;
              out_d       = '{read_value: '0, done_flag: 1'b1, saturated: clip_q};
            end
            ACT_COMP: begin
              clip_d  = 1'b0;
              cnt_d   = '0;
              state_d = ST_SWEEP;
            end
            ACT_READ: begin
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_d       = '{read_value: out_rdata, done_flag: 1'b1, saturated: clip_q};
        state_d     = ST_IDLE;
      end
      ST_SWEEP: begin
        // read input, then write the copy in the next cycle
        in_raddr  = cnt_q[AddrW-1:0];
        sw_vld_d  = !cnt_q[AddrW];
        sw_addr_d = cnt_q[AddrW-1:0];
        if (!cnt_q[AddrW]) begin
          cnt_d = cnt_q + 1'b1;
        end
        out_we    = sw_vld_q;
        out_waddr = sw_addr_q;
        out_wdata = (sw_addr_q[AddrW-1] && (sw_addr_q[AddrW-2 -: StepW] <= last_q))
                    ? in_rdata : '0;
        if (cnt_q[AddrW] && !sw_vld_q) begin
          t_d     = '0;
          a_d     = '0;
          b_d     = '0;
          state_d = ST_RD_F;
        end
      end
      ST_RD_F: begin
        state_d = ST_LD_F;
      end
      ST_LD_F: begin
        f_d     = in_rdata;
        state_d = ST_PF;
      end
      ST_PF: begin
        mul_en     = 1'b1;
        mul_x      = pf_c;
        mul_y      = f_q;
        out_raddr  = here;
        acc_addr_d = here;
        part_d     = 2'd0;
        state_d    = ST_ACC;
      end
      ST_C1: begin
        mul_en  = 1'b1;
        part_d  = 2'd1;
        state_d = ST_CF;
      end
      ST_C2: begin
        mul_en  = 1'b1;
        mul_y   = r2;
        part_d  = 2'd2;
        state_d = ST_CF;
      end
      ST_CF: begin
        mul_en     = 1'b1;
        mul_x      = prod;
        mul_y      = f_q;
        out_raddr  = (part_q == 2'd1) ? stay_addr : nbr_addr;
        acc_addr_d = (part_q == 2'd1) ? stay_addr : nbr_addr;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        out_we = 1'b1;
        clip_d = clip_q | sum_clip;
        if (part_q == 2'd0 && do_trans && stay_ok) begin
          state_d = ST_C1;
        end else if (part_q != 2'd2 && do_trans && nbr_ok) begin
          state_d = ST_C2;
        end else if (last_ent) begin
          state_d = ST_FIN;
        end else begin
          // advance to the next state in b, a, t order
          b_d = b_q + CountW'(1);
          if (b_q == CountMax) begin
            b_d = '0;
            a_d = a_q + CountW'(1);
            if (a_q == CountMax) begin
              a_d = '0;
              t_d = t_q + StepW'(1);
            end
          end
          state_d = ST_RD_F;
        end
      end
      ST_FIN: begin
        out_valid_d = 1'b1;
        out_d       = '{read_value: '0, done_flag: 1'b1, saturated: clip_q};
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      sw_vld_q    <= 1'b0;
      part_q      <= 2'd0;
      t_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pf_q        <= '0;
      dir_q       <= 1'b0;
      last_q      <= LastStepRst;
      for (int i = 0; i < MaxSteps; i++) begin
        dye_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sw_vld_q    <= sw_vld_d;
      part_q      <= part_d;
      t_q         <= t_d;
      a_q         <= a_d;
      b_q         <= b_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_P_FAILURE: pf_q   <= cfg_data_i;
          CFG_DIRECTION: dir_q  <= cfg_data_i[0];
          CFG_LAST_STEP: last_q <= cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end
      if (dye_we) begin
        dye_q[in_data_i.step_index] <= {in_data_i.count_second, in_data_i.count_first,
                                        in_data_i.dye_channel};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q  <= sw_addr_d;
    f_q        <= f_d;
    acc_addr_q <= acc_addr_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire

@@ bench/degradation_step_prob_transition_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degradation_step_prob_transition_unit_tb
// Loads dye entries and Q1.31 tensor entries, runs forward and backward
// transitions under several register settings and reads back the output
// tensor. Every result beat is compared with a software copy of the tensors.
// ----------------------------------------------------------------------------
module degradation_step_prob_transition_unit_tb;
  import dspt_pkg::*;

  localparam int unsigned Depth    = 4096;
  localparam longint      CycleCap = 3_000_000;

  class transition_scoreboard;
    logic [7:0]       dye_entry [MaxSteps];
    logic [ProbW-1:0] prob_in   [Depth];
    logic [ProbW-1:0] prob_out  [Depth];
    logic             clipped;
    logic [ProbW-1:0] p_fail;
    logic             backward;
    logic [StepW-1:0] last_step;
    out_t             pending_q [$];
    int               errors;

    function new();
      foreach (dye_entry[i]) dye_entry[i] = '0;
      foreach (prob_in[i]) begin
        prob_in[i]  = '0;
        prob_out[i] = '0;
      end
      clipped   = 1'b0;
      p_fail    = '0;
      backward  = 1'b0;
      last_step = LastStepRst;
      errors    = 0;
    endfunction

    function automatic logic [11:0] slot(logic plane, int t, int a, int b);
      return {plane, 5'(t), 3'(a), 3'(b)};
    endfunction

    function automatic logic [ProbW-1:0] qmul(logic [ProbW-1:0] x, logic [ProbW-1:0] y);
      logic [63:0] p;
      p = 64'(x) * 64'(y);
      return p[62:31];
    endfunction

    function automatic logic [ProbW-1:0] qdiv(int n, int d);
      if (d == 0 || n >= d) return QOne;
      return 32'((64'(n) << 31) / 64'(d));
    endfunction

    function automatic void accumulate(logic [11:0] idx, logic [ProbW-1:0] v);
      logic [32:0] s;
      s = 33'(prob_out[idx]) + 33'(v);
      if (s > 33'(QOne)) begin
        s = 33'(QOne);
        clipped = 1'b1;
      end
      prob_out[idx] = s[31:0];
    endfunction

    function automatic void run_transition();
      logic [ProbW-1:0] pf, succ, f;
      logic [7:0]       e;
      int               lim, dst, ch, total, x;
      pf   = (p_fail > QOne) ? QOne : p_fail;
      succ = QOne - pf;
      lim  = last_step;
      clipped = 1'b0;
      foreach (prob_out[i]) prob_out[i] = '0;
      for (int t = 0; t <= lim; t++)
        for (int a = 0; a <= MaxDyes; a++)
          for (int b = 0; b <= MaxDyes; b++) begin
            f = prob_in[slot(1'b0, t, a, b)];
            prob_out[slot(1'b1, t, a, b)] = prob_in[slot(1'b1, t, a, b)];
            accumulate(slot(1'b0, t, a, b), qmul(pf, f));
            if (!backward) begin
              if (t + 1 > lim) continue;
              dst = t + 1;
              e   = dye_entry[t];
            end else begin
              if (t == 0) continue;
              dst = t - 1;
              e   = dye_entry[t-1];
            end
            ch = e[1:0];
            if (ch != CH_ONE && ch != CH_TWO) begin
              accumulate(slot(1'b0, dst, a, b), qmul(succ, f));
              continue;
            end
            total = (ch == CH_ONE) ? e[4:2] : e[7:5];
            x     = (ch == CH_ONE) ? a : b;
            if (x < total)
              accumulate(slot(1'b0, dst, a, b), qmul(qmul(succ, QOne - qdiv(x, total)), f));
            if (!backward) begin
              if (x > 0)
                accumulate(slot(1'b0, dst, ch == CH_ONE ? a - 1 : a, ch == CH_TWO ? b - 1 : b),
                           qmul(qmul(succ, qdiv(x, total)), f));
            end else if (x + 1 <= MaxDyes) begin
              accumulate(slot(1'b0, dst, ch == CH_ONE ? a + 1 : a, ch == CH_TWO ? b + 1 : b),
                         qmul(qmul(succ, qdiv(x + 1, total)), f));
            end
          end
    endfunction

    function automatic void write_reg(logic [CfgIdxW-1:0] idx, logic [ProbW-1:0] v);
      case (idx)
        CFG_P_FAILURE: p_fail    = v;
        CFG_DIRECTION: backward  = v[0];
        CFG_LAST_STEP: last_step = v[StepW-1:0];
        default: ;
      endcase
    endfunction

    function automatic void note_item(in_t it);
      out_t        r;
      logic [11:0] idx;
      r   = '0;
      idx = slot(it.broken_plane, it.step_index, it.count_first, it.count_second);
      case (it.action)
        ACT_DYE:  dye_entry[it.step_index] = {it.count_second, it.count_first, it.dye_channel};
        ACT_LOAD: prob_in[idx] = (it.prob_value > QOne) ? QOne : it.prob_value;
        ACT_COMP: run_transition();
        default:  r.read_value = prob_out[idx];
      endcase
      r.done_flag = 1'b1;
      r.saturated = clipped;
      pending_q.push_back(r);
    endfunction

    function automatic void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                 got.read_value);
        errors++;
      end
      if (got.done_flag !== want.done_flag) begin
        $display("%0t: done_flag expected %b actual %b", $time, want.done_flag,
                 got.done_flag);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ProbW-1:0]   cfg_data;

  transition_scoreboard sb = new();
  longint               cycles = 0;
  logic [StepW-1:0]     step_span = LastStepRst;

  degradation_step_prob_transition_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("degradation_step_prob_transition_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver back-pressure: mostly short stalls, now and then a long one or a quiet stretch
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      repeat ($urandom_range(0, 12)) @(posedge clk);
      if (r < 10) begin
        repeat (200) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (r < 20 ? $urandom_range(15, 40) : $urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ProbW-1:0] pick_prob();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return QOne;
      2: return $urandom();
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic send_item(in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [ProbW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    if (idx == CFG_LAST_STEP) step_span = v[StepW-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t make_item(logic [1:0] act);
    in_t it;
    it              = '0;
    it.action       = act;
    it.step_index   = ($urandom_range(0, 9) == 0) ? StepW'($urandom_range(0, 31))
                                                   : StepW'($urandom_range(0, step_span));
    it.dye_channel  = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.count_first  = CountW'($urandom_range(0, 7));
    it.count_second = CountW'($urandom_range(0, 7));
    it.broken_plane = ($urandom_range(0, 4) == 0);
    it.prob_value   = (act == ACT_LOAD) ? pick_prob() : $urandom();
    return it;
  endfunction

  function automatic in_t fixed_item(logic [1:0] act, int t, logic [1:0] ch, int a, int b,
                                     logic plane, logic [ProbW-1:0] p);
    in_t it;
    it.action       = act;
    it.step_index   = StepW'(t);
    it.dye_channel  = ch;
    it.count_first  = CountW'(a);
    it.count_second = CountW'(b);
    it.broken_plane = plane;
    it.prob_value   = p;
    return it;
  endfunction

  initial begin
    int   r;
    int   quota;
    in_t  it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_P_FAILURE;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small tensor, extremes of values and dye channel codes 1 to 3
    write_cfg(CFG_LAST_STEP, 5'd3);
    write_cfg(CFG_P_FAILURE, 32'h2000_0000);
    send_item(fixed_item(ACT_DYE, 0, CH_ONE, 7, 0, 1'b0, '0));
    send_item(fixed_item(ACT_DYE, 1, CH_TWO, 0, 7, 1'b0, '0));
    send_item(fixed_item(ACT_DYE, 2, 2'd3, 5, 5, 1'b0, '0));
    send_item(fixed_item(ACT_DYE, 31, CH_ONE, 0, 0, 1'b0, '0));
    send_item(fixed_item(ACT_LOAD, 0, CH_NONE, 7, 0, 1'b0, QOne));
    send_item(fixed_item(ACT_LOAD, 0, CH_NONE, 0, 0, 1'b0, 32'hFFFF_FFFF));
    send_item(fixed_item(ACT_LOAD, 1, CH_NONE, 3, 7, 1'b0, 32'h4000_0001));
    send_item(fixed_item(ACT_LOAD, 1, CH_NONE, 3, 6, 1'b0, QOne));
    send_item(fixed_item(ACT_LOAD, 2, CH_NONE, 7, 7, 1'b0, 32'h7FFF_FFFF));
    send_item(fixed_item(ACT_LOAD, 3, CH_NONE, 1, 1, 1'b1, 32'h1234_5678));
    send_item(fixed_item(ACT_LOAD, 31, CH_NONE, 7, 7, 1'b1, QOne));
    send_item(fixed_item(ACT_COMP, 0, CH_NONE, 0, 0, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 1, CH_NONE, 6, 0, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 2, CH_NONE, 3, 6, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 3, CH_NONE, 1, 1, 1'b1, '0));
    send_item(fixed_item(ACT_READ, 31, CH_NONE, 7, 7, 1'b1, '0));
    wait_drained();
    write_cfg(CFG_DIRECTION, 1'b1);
    write_cfg(CFG_P_FAILURE, 32'hFFFF_FFFF);
    send_item(fixed_item(ACT_COMP, 0, CH_NONE, 0, 0, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 0, CH_NONE, 0, 0, 1'b0, '0));
    wait_drained();
    write_cfg(CFG_P_FAILURE, '0);
    send_item(fixed_item(ACT_COMP, 0, CH_NONE, 0, 0, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 0, CH_NONE, 7, 1, 1'b0, '0));
    send_item(fixed_item(ACT_READ, 1, CH_NONE, 3, 7, 1'b0, '0));

    // random phases: registers change only while idle
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      r = $urandom_range(0, 3);
      write_cfg(CFG_P_FAILURE, r == 0 ? '0 : r == 1 ? QOne : r == 2 ? 32'hFFFF_FFFF
                                                                     : $urandom_range(0, QOne));
      write_cfg(CFG_DIRECTION, phase[0]);
      write_cfg(CFG_LAST_STEP, phase == 7 ? 5'd31 : phase == 6 ? 5'd0
                                              : 5'($urandom_range(1, 6)));
      quota = 100;
      for (int n = 0; n < quota; n++) begin
        r = $urandom_range(0, 99);
        if (n == quota / 2 || n == quota - 10)
          it = make_item(ACT_COMP);
        else if (r < 15)
          it = make_item(ACT_DYE);
        else if (r < 60)
          it = make_item(ACT_LOAD);
        else
          it = make_item(ACT_READ);
        send_item(it);
        // hold off until every outstanding result is back
        if (phase == 2 && n == 30) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("degradation_step_prob_transition_unit verification clean");
    end else begin
      $display("degradation_step_prob_transition_unit verification failed");
    end
    $finish;
  end

endmodule

@@ degradation_step_prob_transition_unit.f @@
sv/dspt_pkg.sv
sv/dspt_ram.sv
sv/dspt_qmul.sv
sv/degradation_step_prob_transition_unit.sv
bench/degradation_step_prob_transition_unit_tb.sv
